/* hw/rtl/xbr_pkg.sv */
// Package with the shared types, constants and the CRC step of the block receiver.
package xbr_pkg;

    localparam int DEF_ADDR_WIDTH = 24;
    localparam int CAP_WIDTH      = 25;
    localparam int LEN_WIDTH      = 25;
    localparam int MAX_RESULTS    = 3;
    localparam int FIFO_DEPTH     = 4;

    localparam logic [7:0] B_SOH = 8'h01;
    localparam logic [7:0] B_STX = 8'h02;
    localparam logic [7:0] B_EOT = 8'h04;
    localparam logic [7:0] B_ACK = 8'h06;
    localparam logic [7:0] B_NAK = 8'h15;
    localparam logic [7:0] B_CAN = 8'h18;
    localparam logic [7:0] B_C   = 8'h43;

    localparam logic [1:0] CMD_START  = 2'd0;
    localparam logic [1:0] CMD_BYTE   = 2'd1;
    localparam logic [1:0] CMD_TMO    = 2'd2;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam logic [1:0] REG_CAPACITY = 2'd0;
    localparam logic [1:0] REG_RETRANS  = 2'd1;
    localparam logic [1:0] REG_SYNC     = 2'd2;

    localparam logic [1:0] WK_SIX   = 2'd0;
    localparam logic [1:0] WK_THREE = 2'd1;
    localparam logic [1:0] WK_FLUSH = 2'd2;
    localparam logic [1:0] WK_NONE  = 2'd3;

    localparam logic [1:0] ST_NORMAL  = 2'd0;
    localparam logic [1:0] ST_CANCEL  = 2'd1;
    localparam logic [1:0] ST_SYNC    = 2'd2;
    localparam logic [1:0] ST_RETRANS = 2'd3;

    typedef enum logic [4:0] {
        PH_IDLE     = 5'b00001,
        PH_SYNC     = 5'b00010,
        PH_SYNC_CAN = 5'b00100,
        PH_RECV     = 5'b01000,
        PH_FLUSH    = 5'b10000
    } phase_t;

    typedef enum logic [1:0] {
        TRY_NONE = 2'd0,
        TRY_C    = 2'd1,
        TRY_NAK  = 2'd2
    } try_t;

    typedef enum logic [2:0] {
        PR_NONE        = 3'd0,
        PR_ACK_END     = 3'd1,
        PR_ACK_CANCEL  = 3'd2,
        PR_NAK         = 3'd3,
        PR_CAN_SYNC    = 3'd4,
        PR_CAN_RETRANS = 3'd5
    } reply_t;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] rx_byte;
    } in_item_t;

    typedef struct packed {
        logic                        tx_valid;
        logic [7:0]                  tx_byte;
        logic                        data_valid;
        logic [DEF_ADDR_WIDTH-1:0]   data_addr;
        logic [7:0]                  data_byte;
        logic                        commit;
        logic [LEN_WIDTH-1:0]        length;
        logic [1:0]                  wait_kind;
        logic                        done_res;
        logic [1:0]                  status;
        logic                        last;
    } out_item_t;

    // One byte of CRC-16, polynomial 0x1021, most significant bit first.
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ 16'h1021) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

/* hw/rtl/xbr_front.sv */
// Front end: accepts events and runs the protocol state machine, producing result groups.
module xbr_front
    import xbr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  in_item_t             in_item,
    input  logic [CAP_WIDTH-1:0] cap,
    input  logic [7:0]           max_retrans,
    input  logic [7:0]           sync_retries,
    output logic [1:0]           grp_count,
    output out_item_t            grp0,
    output out_item_t            grp1,
    output out_item_t            grp2
);

    phase_t          phase_reg, phase_next;
    logic            large_reg, large_next;
    logic [10:0]     idx_reg, idx_next;
    logic [7:0]      bnum_reg, bnum_next;
    logic [7:0]      bcomp_reg, bcomp_next;
    logic [7:0]      exp_reg, exp_next;
    logic [15:0]     crc_reg, crc_next;
    logic [7:0]      sum_reg, sum_next;
    logic [7:0]      chk_reg, chk_next;
    logic [LEN_WIDTH-1:0] len_reg, len_next;
    logic [7:0]      rl_reg, rl_next;
    logic [7:0]      rc_reg, rc_next;
    try_t            try_reg, try_next;
    logic            crcm_reg, crcm_next;
    reply_t          pr_reg, pr_next;

    localparam logic [LEN_WIDTH:0] ADDR_SPAN = (LEN_WIDTH+1)'(1) << DEF_ADDR_WIDTH;

    logic [LEN_WIDTH:0] lim;
    logic [7:0]         b;
    logic [10:0]        bsz;
    logic [10:0]        total;
    logic [7:0]         slim;
    logic [7:0]         rc_inc;
    logic [LEN_WIDTH:0] addr_w;
    logic [LEN_WIDTH:0] room;
    logic               good;
    out_item_t          blank;
    out_item_t          r0, r1, r2;
    logic [1:0]         n;

    always_comb
    begin
        lim    = ({1'b0, cap} < ADDR_SPAN) ? {1'b0, cap} : ADDR_SPAN;
        b      = in_item.rx_byte;
        bsz    = large_reg ? 11'd1024 : 11'd128;
        total  = bsz + 11'd3 + {10'd0, crcm_reg};
        slim   = (sync_retries == 8'd0) ? 8'd1 : sync_retries;
        rc_inc = rc_reg + 8'd1;
        addr_w = {1'b0, len_reg} + (LEN_WIDTH+1)'(idx_reg - 11'd2);
        room   = lim - {1'b0, len_reg};
        good   = (crcm_reg ? ({chk_reg, b} == crc_reg) : (b == sum_reg))
                 && (bnum_reg == ~bcomp_reg)
                 && (bnum_reg == exp_reg || bnum_reg == exp_reg - 8'd1);

        blank        = '0;
        blank.length = len_reg;
        r0 = blank;
        r1 = blank;
        r2 = blank;
        n  = 2'd0;

        phase_next = phase_reg;  large_next = large_reg;  idx_next = idx_reg;
        bnum_next  = bnum_reg;   bcomp_next = bcomp_reg;  exp_next = exp_reg;
        crc_next   = crc_reg;    sum_next   = sum_reg;    chk_next = chk_reg;
        len_next   = len_reg;    rl_next    = rl_reg;     rc_next  = rc_reg;
        try_next   = try_reg;    crcm_next  = crcm_reg;   pr_next  = pr_reg;

        if (in_valid) begin
            if (in_item.command == CMD_START) begin
                phase_next = PH_SYNC; large_next = 1'b0; idx_next = '0;
                bnum_next = '0; bcomp_next = '0; exp_next = 8'd1; crc_next = '0;
                sum_next = '0; chk_next = '0; len_next = '0; rl_next = max_retrans;
                rc_next = '0; try_next = TRY_C; crcm_next = 1'b0; pr_next = PR_NONE;
                r0.tx_valid = 1'b1;
                r0.tx_byte  = B_C;
                r0.length   = '0;
                n = 2'd1;
            end else if (in_item.command == CMD_BYTE || in_item.command == CMD_TMO) begin
                logic tmo;
                logic do_retry;
                tmo      = (in_item.command == CMD_TMO);
                do_retry = 1'b0;
                unique case (phase_reg)
                    PH_SYNC:
                    begin
                        if (tmo) do_retry = 1'b1;
                        else if (b == B_SOH || b == B_STX) begin
                            large_next = (b == B_STX);
                            if (try_reg == TRY_C) crcm_next = 1'b1;
                            try_next = TRY_NONE; idx_next = '0; crc_next = '0;
                            sum_next = '0; chk_next = '0; phase_next = PH_RECV;
                            r0.wait_kind = WK_THREE; n = 2'd1;
                        end else if (b == B_EOT) begin
                            pr_next = PR_ACK_END; phase_next = PH_FLUSH;
                            r0.wait_kind = WK_FLUSH; n = 2'd1;
                        end else if (b == B_CAN) begin
                            phase_next = PH_SYNC_CAN;
                            r0.wait_kind = WK_THREE; n = 2'd1;
                        end else do_retry = 1'b1;
                    end
                    PH_SYNC_CAN:
                    begin
                        if (!tmo && b == B_CAN) begin
                            pr_next = PR_ACK_CANCEL; phase_next = PH_FLUSH;
                            r0.wait_kind = WK_FLUSH; n = 2'd1;
                        end else do_retry = 1'b1;
                    end
                    PH_RECV:
                    begin
                        n = 2'd1;
                        if (tmo) begin
                            pr_next = PR_NAK; phase_next = PH_FLUSH;
                            r0.wait_kind = WK_FLUSH;
                        end else begin
                            idx_next = idx_reg + 11'd1;
                            r0.wait_kind = WK_THREE;
                            if (idx_reg == 11'd0) bnum_next = b;
                            else if (idx_reg == 11'd1) bcomp_next = b;
                            else if (idx_reg < bsz + 11'd2) begin
                                crc_next = crc_byte(crc_reg, b);
                                sum_next = sum_reg + b;
                                if (addr_w < lim) begin
                                    r0.data_valid = 1'b1;
                                    r0.data_addr  = addr_w[DEF_ADDR_WIDTH-1:0];
                                    r0.data_byte  = b;
                                end
                            end else if (idx_reg + 11'd1 >= total) begin
                                if (!good) begin
                                    pr_next = PR_NAK; phase_next = PH_FLUSH;
                                    r0.wait_kind = WK_FLUSH;
                                end else if (bnum_reg == exp_reg) begin
                                    if (room[LEN_WIDTH] == 1'b0 && room != '0) begin
                                        len_next = (room > (LEN_WIDTH+1)'(bsz))
                                            ? len_reg + LEN_WIDTH'(bsz)
                                            : LEN_WIDTH'(lim);
                                    end
                                    exp_next = exp_reg + 8'd1;
                                    rl_next  = max_retrans;
                                    r0.commit = 1'b1;
                                    r0.length = len_next;
                                    if (max_retrans == 8'd0) begin
                                        pr_next = PR_CAN_RETRANS; phase_next = PH_FLUSH;
                                        r0.wait_kind = WK_FLUSH;
                                    end else begin
                                        phase_next = PH_SYNC; rc_next = '0;
                                        r0.tx_valid = 1'b1; r0.tx_byte = B_ACK;
                                        r0.wait_kind = WK_SIX;
                                    end
                                end else if (rl_reg <= 8'd1) begin
                                    rl_next = '0;
                                    pr_next = PR_CAN_RETRANS; phase_next = PH_FLUSH;
                                    r0.wait_kind = WK_FLUSH;
                                end else begin
                                    rl_next = rl_reg - 8'd1;
                                    phase_next = PH_SYNC; rc_next = '0;
                                    r0.tx_valid = 1'b1; r0.tx_byte = B_ACK;
                                    r0.wait_kind = WK_SIX;
                                end
                            end else chk_next = b;
                        end
                    end
                    PH_FLUSH:
                    begin
                        n = 2'd1;
                        if (!tmo) r0.wait_kind = WK_FLUSH;
                        else begin
                            pr_next = PR_NONE;
                            r0.wait_kind = WK_NONE;
                            case (pr_reg)
                                PR_ACK_END, PR_ACK_CANCEL:
                                begin
                                    phase_next = PH_IDLE;
                                    r0.tx_valid = 1'b1; r0.tx_byte = B_ACK;
                                    r0.done_res = 1'b1;
                                    r0.status = (pr_reg == PR_ACK_CANCEL) ? ST_CANCEL
                                                                          : ST_NORMAL;
                                end
                                PR_NAK:
                                begin
                                    phase_next = PH_SYNC; rc_next = '0;
                                    r0.tx_valid = 1'b1; r0.tx_byte = B_NAK;
                                    r0.wait_kind = WK_SIX;
                                end
                                PR_CAN_SYNC, PR_CAN_RETRANS:
                                begin
                                    phase_next = PH_IDLE;
                                    r0.tx_valid = 1'b1; r0.tx_byte = B_CAN;
                                    r1 = r0; r2 = r0;
                                    r2.done_res = 1'b1;
                                    r2.status = (pr_reg == PR_CAN_SYNC) ? ST_SYNC
                                                                        : ST_RETRANS;
                                    n = 2'd3;
                                end
                                default: phase_next = PH_IDLE;
                            endcase
                        end
                    end
                    default: n = 2'd0;
                endcase
                if (do_retry) begin
                    phase_next = PH_SYNC;
                    n = 2'd1;
                    rc_next = rc_inc;
                    if (rc_inc < slim) begin
                        r0.tx_valid = (try_reg != TRY_NONE);
                        r0.tx_byte  = (try_reg == TRY_C) ? B_C
                                    : (try_reg == TRY_NAK) ? B_NAK : 8'h00;
                    end else if (try_reg == TRY_C) begin
                        try_next = TRY_NAK; rc_next = '0;
                        r0.tx_valid = 1'b1; r0.tx_byte = B_NAK;
                    end else begin
                        pr_next = PR_CAN_SYNC; phase_next = PH_FLUSH;
                        r0.wait_kind = WK_FLUSH;
                    end
                end
            end
        end
        unique case (n)
            2'd1: r0.last = 1'b1;
            2'd3: r2.last = 1'b1;
            default: ;
        endcase
        grp_count = n;
        grp0 = r0;
        grp1 = r1;
        grp2 = r2;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg <= PH_IDLE; large_reg <= 1'b0; idx_reg <= '0; bnum_reg <= '0;
            bcomp_reg <= '0; exp_reg <= 8'd1; crc_reg <= '0; sum_reg <= '0;
            chk_reg <= '0; len_reg <= '0; rl_reg <= 8'd25; rc_reg <= '0;
            try_reg <= TRY_C; crcm_reg <= 1'b0; pr_reg <= PR_NONE;
        end else begin
            phase_reg <= phase_next; large_reg <= large_next; idx_reg <= idx_next;
            bnum_reg <= bnum_next; bcomp_reg <= bcomp_next; exp_reg <= exp_next;
            crc_reg <= crc_next; sum_reg <= sum_next; chk_reg <= chk_next;
            len_reg <= len_next; rl_reg <= rl_next; rc_reg <= rc_next;
            try_reg <= try_next; crcm_reg <= crcm_next; pr_reg <= pr_next;
        end
    end

endmodule

/* hw/rtl/xbr_queue.sv */
// Result queue between the state machine and the result port; takes up to three beats at once.
module xbr_queue
    import xbr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic [1:0] wr_count,
    input  out_item_t wr0,
    input  out_item_t wr1,
    input  out_item_t wr2,
    output logic      room,
    output logic      empty,
    input  logic      pop,
    output out_item_t head
);

    localparam int PW = $clog2(FIFO_DEPTH);

    out_item_t       mem_reg [FIFO_DEPTH];
    logic [PW-1:0]   rd_reg, wr_reg;
    logic [PW:0]     cnt_reg;
    logic            do_pop;

    assign empty  = (cnt_reg == '0);
    assign do_pop = pop && !empty;
    assign head   = mem_reg[rd_reg];
    // Room for a worst-case group of three beats.
    assign room   = (cnt_reg <= (PW+1)'(FIFO_DEPTH - MAX_RESULTS));

    always_ff @(posedge clk)
    begin
        if (wr_count >= 2'd1) mem_reg[wr_reg] <= wr0;
        if (wr_count >= 2'd2) mem_reg[wr_reg + PW'(1)] <= wr1;
        if (wr_count >= 2'd3) mem_reg[wr_reg + PW'(2)] <= wr2;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            rd_reg  <= '0;
            wr_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_reg + PW'(wr_count);
            rd_reg  <= rd_reg + PW'(do_pop);
            cnt_reg <= cnt_reg + (PW+1)'(wr_count) - (PW+1)'(do_pop);
        end
    end

endmodule

/* hw/rtl/xmodem_block_receiver_unit.sv */
// Top level of the block receiver: configuration registers, state machine and result queue.
// Results: the results of an accepted event are registered in the result queue.
// Throughput: one event per cycle while the queue has room for three beats; an event
// that yields three results occupies three queue slots, which drain at one beat a cycle while pop is high.
// Reset: asynchronous, active low; registers return to defaults and the queue empties.
module xmodem_block_receiver_unit
    import xbr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  in_item_t             in_item,
    output logic                 empty,
    input  logic                 pop,
    output out_item_t            out_item,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_index,
    input  logic [CAP_WIDTH-1:0] cfg_data
);

    logic [CAP_WIDTH-1:0] cap_reg;
    logic [7:0]           retrans_reg;
    logic [7:0]           sync_reg;
    logic                 room;
    logic                 accept;
    logic [1:0]           grp_count;
    out_item_t            g0, g1, g2;

    // The user must write the configuration only while idle, so a plain register file suffices; not enforced here.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cap_reg     <= CAP_WIDTH'(16777216);
            retrans_reg <= 8'd25;
            sync_reg    <= 8'd16;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_CAPACITY: cap_reg     <= cfg_data;
                REG_RETRANS:  retrans_reg <= cfg_data[7:0];
                REG_SYNC:     sync_reg    <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // An event is taken whenever the queue can hold every beat it might produce.
    assign full   = !room;
    assign accept = push && room;

    xbr_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (accept),
        .in_item      (in_item),
        .cap          (cap_reg),
        .max_retrans  (retrans_reg),
        .sync_retries (sync_reg),
        .grp_count    (grp_count),
        .grp0         (g0),
        .grp1         (g1),
        .grp2         (g2)
    );

    xbr_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_count (grp_count),
        .wr0      (g0),
        .wr1      (g1),
        .wr2      (g2),
        .room     (room),
        .empty    (empty),
        .pop      (pop),
        .head     (out_item)
    );

endmodule

/* tb/tb_xmodem_block_receiver_unit.sv */
// Self-checking testbench for the XMODEM block receiver unit.
module tb_xmodem_block_receiver_unit;
    import xbr_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int IDLE_WAIT   = 8;
    localparam int HOLD_AT     = 40;
    localparam int HOLD_LEN    = 300;
    localparam int FLAW_NONE   = 0;
    localparam int FLAW_CHECK  = 1;
    localparam int FLAW_COMPL  = 2;
    localparam int FLAW_SHORT  = 3;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 push = 1'b0;
    logic                 full;
    in_item_t             in_item = '0;
    logic                 empty;
    logic                 pop = 1'b0;
    out_item_t            out_item;
    logic                 cfg_we = 1'b0;
    logic [1:0]           cfg_index = REG_CAPACITY;
    logic [CAP_WIDTH-1:0] cfg_data = '0;

    xmodem_block_receiver_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .in_item   (in_item),
        .empty     (empty),
        .pop       (pop),
        .out_item  (out_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Events waiting to be offered, and the results that the receiver owes us.
    in_item_t  events_to_send[$];
    out_item_t owed_results[$];
    out_item_t step_results[$];
    bit        failed = 1'b0;
    int        cycles = 0;

    // Our own copy of the receiver's registers and protocol state.
    logic [24:0] capacity;
    logic [7:0]  retrans_max;
    logic [7:0]  sync_max;
    phase_t      phase;
    logic        big_block;
    logic [10:0] offset;
    logic [7:0]  blk_num;
    logic [7:0]  blk_compl;
    logic [7:0]  want_num;
    logic [15:0] crc_acc;
    logic [7:0]  sum_acc;
    logic [7:0]  crc_hi;
    logic [24:0] committed;
    logic [7:0]  retrans_left;
    logic [7:0]  retries;
    try_t        handshake;
    logic        use_crc;
    reply_t      reply;

    initial
    begin
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb_xmodem_block_receiver_unit NOT OK");
            $finish;
        end
    end

    function automatic logic [15:0] crc16_next(logic [15:0] crc, logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++)
            c = c[15] ? ({c[14:0], 1'b0} ^ 16'h1021) : {c[14:0], 1'b0};
        return c;
    endfunction

    // The receiver never stores past 2^24 bytes, whatever the capacity register says.
    function automatic logic [25:0] store_limit();
        return (capacity < 25'h1000000) ? {1'b0, capacity} : 26'h1000000;
    endfunction

    // Queues one result of the current event; an event never yields more than three.
    function automatic void note(bit txv, logic [7:0] txb, bit dv, logic [23:0] a,
                                 logic [7:0] db, bit cm, logic [1:0] wk, bit dn,
                                 logic [1:0] st);
        out_item_t r;
        if (step_results.size() >= MAX_RESULTS)
            return;
        r.tx_valid   = txv;
        r.tx_byte    = txb;
        r.data_valid = dv;
        r.data_addr  = a;
        r.data_byte  = db;
        r.commit     = cm;
        r.length     = committed;
        r.wait_kind  = wk;
        r.done_res   = dn;
        r.status     = st;
        r.last       = 1'b0;
        step_results.push_back(r);
    endfunction

    function automatic void clear_state();
        phase        = PH_IDLE;
        big_block    = 1'b0;
        offset       = '0;
        blk_num      = '0;
        blk_compl    = '0;
        want_num     = 8'd1;
        crc_acc      = '0;
        sum_acc      = '0;
        crc_hi       = '0;
        committed    = '0;
        retrans_left = retrans_max;
        retries      = '0;
        handshake    = TRY_C;
        use_crc      = 1'b0;
        reply        = PR_NONE;
    endfunction

    function automatic void send_handshake();
        if (handshake == TRY_C)
            note(1, B_C, 0, 0, 0, 0, WK_SIX, 0, ST_NORMAL);
        else if (handshake == TRY_NAK)
            note(1, B_NAK, 0, 0, 0, 0, WK_SIX, 0, ST_NORMAL);
        else
            note(0, 0, 0, 0, 0, 0, WK_SIX, 0, ST_NORMAL);
    endfunction

    function automatic void go_flush(reply_t r, bit cm);
        reply = r;
        phase = PH_FLUSH;
        note(0, 0, 0, 0, 0, cm, WK_FLUSH, 0, ST_NORMAL);
    endfunction

    // A wait expired or junk arrived while synchronising: retry, fall back, or give up.
    function automatic void retry_sync();
        logic [7:0] lim;
        lim = (sync_max != 0) ? sync_max : 8'd1;
        retries = retries + 8'd1;
        phase = PH_SYNC;
        if (retries < lim)
            send_handshake();
        else if (handshake == TRY_C)
        begin
            handshake = TRY_NAK;
            retries = '0;
            send_handshake();
        end
        else
            go_flush(PR_CAN_SYNC, 0);
    endfunction

    function automatic void close_block(logic [7:0] b);
        bit          good;
        logic [7:0]  prev;
        logic [25:0] lim;
        logic [25:0] room;
        logic [25:0] bsz;
        prev = want_num - 8'd1;
        bsz  = big_block ? 26'd1024 : 26'd128;
        good = use_crc ? ({crc_hi, b} == crc_acc) : (b == sum_acc);
        good = good && (blk_num == ~blk_compl) && (blk_num == want_num || blk_num == prev);
        if (!good)
        begin
            go_flush(PR_NAK, 0);
            return;
        end
        if (blk_num == want_num)
        begin
            lim = store_limit();
            if (committed < lim)
            begin
                room = lim - committed;
                if (room > bsz)
                    room = bsz;
                committed = committed + room[24:0];
            end
            want_num = want_num + 8'd1;
            retrans_left = retrans_max;
            if (retrans_left == 0)
            begin
                go_flush(PR_CAN_RETRANS, 1);
                return;
            end
            phase = PH_SYNC;
            retries = '0;
            note(1, B_ACK, 0, 0, 0, 1, WK_SIX, 0, ST_NORMAL);
            return;
        end
        // A repeat of the previous block counts against the limit; it is acknowledged while retransmits remain.
        if (retrans_left <= 1)
        begin
            retrans_left = '0;
            go_flush(PR_CAN_RETRANS, 0);
            return;
        end
        retrans_left = retrans_left - 8'd1;
        phase = PH_SYNC;
        retries = '0;
        note(1, B_ACK, 0, 0, 0, 0, WK_SIX, 0, ST_NORMAL);
    endfunction

    function automatic void take_block_byte(logic [7:0] b);
        logic [10:0] bsz;
        logic [10:0] total;
        logic [10:0] idx;
        logic [25:0] a;
        bsz   = big_block ? 11'd1024 : 11'd128;
        total = bsz + 11'd3 + (use_crc ? 11'd1 : 11'd0);
        idx   = offset;
        offset = offset + 11'd1;
        if (idx == 0)
        begin
            blk_num = b;
            note(0, 0, 0, 0, 0, 0, WK_THREE, 0, ST_NORMAL);
        end
        else if (idx == 1)
        begin
            blk_compl = b;
            note(0, 0, 0, 0, 0, 0, WK_THREE, 0, ST_NORMAL);
        end
        else if (idx < bsz + 11'd2)
        begin
            // Payload goes out at once; it only counts once the block is accepted.
            a = committed + (idx - 11'd2);
            crc_acc = crc16_next(crc_acc, b);
            sum_acc = sum_acc + b;
            if (a < store_limit())
                note(0, 0, 1, a[23:0], b, 0, WK_THREE, 0, ST_NORMAL);
            else
                note(0, 0, 0, 0, 0, 0, WK_THREE, 0, ST_NORMAL);
        end
        else if (idx + 11'd1 >= total)
            close_block(b);
        else
        begin
            crc_hi = b;
            note(0, 0, 0, 0, 0, 0, WK_THREE, 0, ST_NORMAL);
        end
    endfunction

    function automatic void flush_over();
        reply_t r;
        r = reply;
        reply = PR_NONE;
        case (r)
            PR_ACK_END:
            begin
                phase = PH_IDLE;
                note(1, B_ACK, 0, 0, 0, 0, WK_NONE, 1, ST_NORMAL);
            end
            PR_ACK_CANCEL:
            begin
                phase = PH_IDLE;
                note(1, B_ACK, 0, 0, 0, 0, WK_NONE, 1, ST_CANCEL);
            end
            PR_NAK:
            begin
                phase = PH_SYNC;
                retries = '0;
                note(1, B_NAK, 0, 0, 0, 0, WK_SIX, 0, ST_NORMAL);
            end
            PR_CAN_SYNC, PR_CAN_RETRANS:
            begin
                phase = PH_IDLE;
                note(1, B_CAN, 0, 0, 0, 0, WK_NONE, 0, ST_NORMAL);
                note(1, B_CAN, 0, 0, 0, 0, WK_NONE, 0, ST_NORMAL);
                note(1, B_CAN, 0, 0, 0, 0, WK_NONE, 1,
                     (r == PR_CAN_SYNC) ? ST_SYNC : ST_RETRANS);
            end
            default:
            begin
                phase = PH_IDLE;
                note(0, 0, 0, 0, 0, 0, WK_NONE, 0, ST_NORMAL);
            end
        endcase
    endfunction

    function automatic void start_block(bit big);
        big_block = big;
        if (handshake == TRY_C)
            use_crc = 1'b1;
        handshake = TRY_NONE;
        offset  = '0;
        crc_acc = '0;
        sum_acc = '0;
        crc_hi  = '0;
        phase   = PH_RECV;
        note(0, 0, 0, 0, 0, 0, WK_THREE, 0, ST_NORMAL);
    endfunction

    // Works out every result of one accepted event and adds them to the owed list.
    function automatic void predict_event(in_item_t ev);
        bit tmo;
        step_results.delete();
        tmo = (ev.command == CMD_TMO);
        if (ev.command == CMD_START)
        begin
            clear_state();
            phase = PH_SYNC;
            send_handshake();
        end
        else if (ev.command == CMD_BYTE || tmo)
        begin
            case (phase)
                PH_SYNC:
                begin
                    if (tmo)
                        retry_sync();
                    else if (ev.rx_byte == B_SOH)
                        start_block(0);
                    else if (ev.rx_byte == B_STX)
                        start_block(1);
                    else if (ev.rx_byte == B_EOT)
                        go_flush(PR_ACK_END, 0);
                    else if (ev.rx_byte == B_CAN)
                    begin
                        phase = PH_SYNC_CAN;
                        note(0, 0, 0, 0, 0, 0, WK_THREE, 0, ST_NORMAL);
                    end
                    else
                        retry_sync();
                end
                PH_SYNC_CAN:
                begin
                    if (!tmo && ev.rx_byte == B_CAN)
                        go_flush(PR_ACK_CANCEL, 0);
                    else
                        retry_sync();
                end
                PH_RECV:
                begin
                    if (tmo)
                        go_flush(PR_NAK, 0);
                    else
                        take_block_byte(ev.rx_byte);
                end
                PH_FLUSH:
                begin
                    // Line noise during the flush just restarts the silence wait.
                    if (tmo)
                        flush_over();
                    else
                        note(0, 0, 0, 0, 0, 0, WK_FLUSH, 0, ST_NORMAL);
                end
                default:
                begin
                end
            endcase
        end
        if (step_results.size() > 0)
            step_results[step_results.size()-1].last = 1'b1;
        foreach (step_results[i])
            owed_results.push_back(step_results[i]);
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Sender side: one beat per handshake, with random gaps between beats.
    always @(posedge clk)
    begin : sender
        int gap;
        if (rst_n)
        begin
            if (push && !full)
                predict_event(in_item);
            if (!push || !full)
            begin
                if (gap > 0)
                begin
                    gap = gap - 1;
                    push <= 1'b0;
                end
                else if (events_to_send.size() > 0)
                begin
                    in_item <= events_to_send.pop_front();
                    push <= 1'b1;
                    gap = pick_gap();
                end
                else
                    push <= 1'b0;
            end
        end
    end

    function automatic void compare(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            failed = 1'b1;
        end
    endfunction

    // Result side: checks each beat against the oldest owed result. After HOLD_AT
    // beats it stops taking results for a long stretch so the queue backs up.
    always @(posedge clk)
    begin : receiver
        int        stall;
        int        hold;
        int        beats;
        out_item_t want;
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                beats = beats + 1;
                if (owed_results.size() == 0)
                begin
                    $error("result beat arrived with nothing owed");
                    failed = 1'b1;
                end
                else
                begin
                    want = owed_results.pop_front();
                    compare("tx_valid", 32'(want.tx_valid), 32'(out_item.tx_valid));
                    compare("tx_byte", 32'(want.tx_byte), 32'(out_item.tx_byte));
                    compare("data_valid", 32'(want.data_valid), 32'(out_item.data_valid));
                    compare("data_addr", 32'(want.data_addr), 32'(out_item.data_addr));
                    compare("data_byte", 32'(want.data_byte), 32'(out_item.data_byte));
                    compare("commit", 32'(want.commit), 32'(out_item.commit));
                    compare("length", 32'(want.length), 32'(out_item.length));
                    compare("wait_kind", 32'(want.wait_kind), 32'(out_item.wait_kind));
                    compare("done_res", 32'(want.done_res), 32'(out_item.done_res));
                    compare("status", 32'(want.status), 32'(out_item.status));
                    compare("last", 32'(want.last), 32'(out_item.last));
                end
                if (beats == HOLD_AT)
                    hold = HOLD_LEN;
            end
            if (hold > 0)
            begin
                hold = hold - 1;
                pop <= 1'b0;
            end
            else if (stall > 0)
            begin
                stall = stall - 1;
                pop <= 1'b0;
            end
            else
            begin
                pop <= 1'b1;
                stall = pick_gap();
            end
        end
    end

    task automatic put(logic [1:0] cmd, logic [7:0] b);
        in_item_t ev;
        ev.command = cmd;
        ev.rx_byte = b;
        events_to_send.push_back(ev);
    endtask

    // Waits until every event is in and every owed result is out, then lets any
    // event that yields nothing work its way through.
    task automatic drain();
        while (events_to_send.size() > 0 || push || owed_results.size() > 0)
            @(posedge clk);
        repeat (IDLE_WAIT) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [CAP_WIDTH-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        if (idx == REG_CAPACITY)
            capacity = val;
        else if (idx == REG_RETRANS)
            retrans_max = val[7:0];
        else if (idx == REG_SYNC)
            sync_max = val[7:0];
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Sends one framed block; a flaw spoils the check, the complement, or cuts it short.
    task automatic send_block(bit big, logic [7:0] num, bit crc, int flaw);
        logic [15:0] c;
        logic [7:0]  s;
        logic [7:0]  b;
        int          n;
        int          cut;
        c = '0;
        s = '0;
        n = big ? 1024 : 128;
        cut = (flaw == FLAW_SHORT) ? $urandom_range(0, n + 2) : n + 10;
        put(CMD_BYTE, big ? B_STX : B_SOH);
        put(CMD_BYTE, num);
        put(CMD_BYTE, (flaw == FLAW_COMPL) ? num : ~num);
        for (int i = 0; i < n; i++)
        begin
            if (i == cut)
            begin
                put(CMD_TMO, 8'h00);
                put(CMD_BYTE, 8'($urandom_range(0, 255)));
                put(CMD_TMO, 8'h00);
                return;
            end
            case ($urandom_range(0, 7))
                0: b = 8'h00;
                1: b = 8'hFF;
                default: b = 8'($urandom_range(0, 255));
            endcase
            c = crc16_next(c, b);
            s = s + b;
            put(CMD_BYTE, b);
        end
        if (flaw == FLAW_CHECK)
        begin
            c = c ^ 16'h0001;
            s = s ^ 8'h80;
        end
        if (crc)
        begin
            put(CMD_BYTE, c[15:8]);
            put(CMD_BYTE, c[7:0]);
        end
        else
            put(CMD_BYTE, s);
        if (flaw == FLAW_CHECK || flaw == FLAW_COMPL)
            put(CMD_TMO, 8'h00);
    endtask

    // One random transfer: a start, some handshake timeouts, blocks, and an ending.
    task automatic random_transfer();
        int         waits;
        int         flaw;
        int         r;
        logic [7:0] num;
        bit         crc;
        put(CMD_START, 8'($urandom_range(0, 255)));
        waits = $urandom_range(0, 3);
        repeat (waits) put(CMD_TMO, 8'($urandom_range(0, 255)));
        crc = (waits < 2);
        num = 8'd1;
        repeat ($urandom_range(1, 3))
        begin
            r = $urandom_range(0, 99);
            flaw = (r < 75) ? FLAW_NONE : (r < 83) ? FLAW_CHECK :
                   (r < 90) ? FLAW_COMPL : FLAW_SHORT;
            if (r >= 95)
                send_block(0, num - 8'd1, crc, FLAW_NONE);
            else
            begin
                send_block($urandom_range(0, 15) == 0, num, crc, flaw);
                if (flaw == FLAW_NONE)
                    num = num + 8'd1;
            end
            if ($urandom_range(0, 9) == 0)
                put(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
        end
        if ($urandom_range(0, 5) == 0)
        begin
            put(CMD_BYTE, B_CAN);
            put(CMD_BYTE, B_CAN);
        end
        else
            put(CMD_BYTE, B_EOT);
        put(CMD_TMO, 8'h00);
    endtask

    initial
    begin
        capacity    = 25'h1000000;
        retrans_max = 8'd25;
        sync_max    = 8'd16;
        clear_state();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part at the reset settings. Events before a start and the unused
        // command code must give nothing.
        put(CMD_TMO, 8'h00);
        put(CMD_BYTE, 8'hFF);
        put(CMD_UNUSED, 8'hAA);
        put(CMD_START, 8'h00);
        send_block(0, 8'd1, 1, FLAW_NONE);
        send_block(0, 8'd1, 1, FLAW_NONE);
        send_block(0, 8'd7, 1, FLAW_NONE);
        put(CMD_TMO, 8'h00);
        send_block(0, 8'd2, 1, FLAW_SHORT);
        send_block(0, 8'd2, 1, FLAW_CHECK);
        send_block(1, 8'd2, 1, FLAW_NONE);
        put(CMD_BYTE, 8'h55);
        put(CMD_BYTE, B_EOT);
        put(CMD_BYTE, 8'h00);
        put(CMD_TMO, 8'h00);
        put(CMD_START, 8'hFF);
        put(CMD_BYTE, B_CAN);
        put(CMD_BYTE, B_CAN);
        put(CMD_TMO, 8'h00);
        drain();

        // Zero sync retries behave as one; the handshake falls back to NAK, then gives up.
        write_reg(REG_SYNC, 25'd0);
        write_reg(REG_RETRANS, 25'd1);
        write_reg(REG_CAPACITY, 25'd200);
        put(CMD_START, 8'h00);
        put(CMD_TMO, 8'h00);
        put(CMD_BYTE, B_CAN);
        put(CMD_TMO, 8'h00);
        put(CMD_TMO, 8'h00);
        put(CMD_START, 8'h00);
        put(CMD_TMO, 8'h00);
        send_block(0, 8'd1, 0, FLAW_NONE);
        send_block(0, 8'd2, 0, FLAW_NONE);
        send_block(0, 8'd2, 0, FLAW_NONE);
        put(CMD_TMO, 8'h00);
        drain();

        // A capacity below the stored length stops storage; zero retransmits aborts.
        write_reg(REG_SYNC, 25'd255);
        put(CMD_START, 8'h00);
        send_block(0, 8'd1, 1, FLAW_NONE);
        drain();
        write_reg(REG_CAPACITY, 25'd50);
        write_reg(REG_RETRANS, 25'd0);
        send_block(0, 8'd2, 1, FLAW_NONE);
        put(CMD_TMO, 8'h00);
        drain();
        write_reg(REG_CAPACITY, 25'd0);
        write_reg(REG_RETRANS, 25'd255);
        put(CMD_START, 8'h00);
        send_block(0, 8'd1, 1, FLAW_NONE);
        put(CMD_BYTE, B_EOT);
        put(CMD_TMO, 8'h00);
        drain();

        // Random transfers; the sender pauses for every owed result between settings.
        write_reg(REG_CAPACITY, 25'h1FFFFFF);
        write_reg(REG_RETRANS, 25'd25);
        write_reg(REG_SYNC, 25'd2);
        repeat (4) random_transfer();
        drain();
        write_reg(REG_CAPACITY, CAP_WIDTH'($urandom_range(100, 400)));
        write_reg(REG_RETRANS, CAP_WIDTH'($urandom_range(1, 3)));
        repeat (4) random_transfer();
        drain();

        if (!failed)
            $display("tb_xmodem_block_receiver_unit OK");
        else
            $display("tb_xmodem_block_receiver_unit NOT OK");
        $finish;
    end

endmodule
